/* hw/rtl/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, constants and square arithmetic for the Playfair cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQUARE_SIDE  = 5;
   localparam int CELL_COUNT   = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_COUNT = 26;
   localparam int LETTER_W     = $clog2(LETTER_COUNT);
   localparam int CELL_W       = $clog2(CELL_COUNT);
   localparam int SIDE_W       = $clog2(SQUARE_SIDE);
   localparam int ASCII_W      = 7;
   localparam int ACTION_W     = 2;

   localparam logic [ASCII_W-1:0]  ASCII_A = 7'd65;
   localparam logic [ASCII_W-1:0]  ASCII_Z = 7'd90;
   localparam logic [LETTER_W-1:0] IDX_I   = 5'd8;
   localparam logic [LETTER_W-1:0] IDX_J   = 5'd9;
   localparam logic [LETTER_W-1:0] IDX_X   = 5'd23;
   localparam logic [LETTER_W-1:0] IDX_LAST = LETTER_W'(LETTER_COUNT - 1);
   localparam logic [CELL_W:0]     CELLS_FULL = (CELL_W + 1)'(CELL_COUNT);

   typedef enum logic [ACTION_W-1:0] {
      ACT_KEY    = 2'd0,
      ACT_FINISH = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD_A,
      ST_RD_B,
      ST_SQ1,
      ST_EMIT1,
      ST_SQ2,
      ST_EMIT2
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0] own_pos;
      logic [CELL_W-1:0] other_pos;
      logic              decrypt;
   } cell_req_type;

   function automatic logic [SIDE_W-1:0] pos_row(input logic [CELL_W-1:0] pos);
      logic [SIDE_W-1:0] row;
      if (pos < CELL_W'(SQUARE_SIDE)) begin
         row = SIDE_W'(0);
      end else if (pos < CELL_W'(2 * SQUARE_SIDE)) begin
         row = SIDE_W'(1);
      end else if (pos < CELL_W'(3 * SQUARE_SIDE)) begin
         row = SIDE_W'(2);
      end else if (pos < CELL_W'(4 * SQUARE_SIDE)) begin
         row = SIDE_W'(3);
      end else begin
         row = SIDE_W'(4);
      end
      return row;
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(input logic [SIDE_W-1:0] row,
                                                 input logic [SIDE_W-1:0] col);
      logic [CELL_W-1:0] r;
      r = CELL_W'(row);
      return (r << 2) + r + CELL_W'(col);
   endfunction

   function automatic logic [SIDE_W-1:0] pos_col(input logic [CELL_W-1:0] pos);
      return SIDE_W'(pos - cell_of(pos_row(pos), SIDE_W'(0)));
   endfunction

   // forward step is +1, backward step is +(side-1), both modulo the side
   function automatic logic [SIDE_W-1:0] side_step(input logic [SIDE_W-1:0] v,
                                                   input logic decrypt);
      logic [SIDE_W:0] sum;
      sum = {1'b0, v} + (decrypt ? (SIDE_W + 1)'(SQUARE_SIDE - 1) : (SIDE_W + 1)'(1));
      if (sum >= (SIDE_W + 1)'(SQUARE_SIDE)) begin
         sum = sum - (SIDE_W + 1)'(SQUARE_SIDE);
      end
      return SIDE_W'(sum);
   endfunction

endpackage

/* hw/rtl/pfc_req_if.sv */
// ----------------------------------------------------------------------------
// Playfair request channel
// Valid/ready channel carrying one key or text action and its letter.
// ----------------------------------------------------------------------------
interface pfc_req_if;
   import pfc_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ASCII_W-1:0]  letter;

   modport source (output valid, output action, output letter, input ready);
   modport sink   (input valid, input action, input letter, output ready);
endinterface

/* hw/rtl/pfc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Playfair response channel
// Valid/ready channel carrying one letter of a transformed digraph.
// ----------------------------------------------------------------------------
interface pfc_rsp_if;
   import pfc_pkg::*;

   logic               valid;
   logic               ready;
   logic [ASCII_W-1:0] out_letter;
   logic               pair_end;

   modport source (output valid, output out_letter, output pair_end, input ready);
   modport sink   (input valid, input out_letter, input pair_end, output ready);
endinterface

/* hw/rtl/pfc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pfc_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/pfc_cell_unit.sv */
// ----------------------------------------------------------------------------
// Playfair cell unit
// Maps one letter's square position to the cell of its cipher partner.
// ----------------------------------------------------------------------------
module pfc_cell_unit (
   input  pfc_pkg::cell_req_type        cell_req,
   output logic [pfc_pkg::CELL_W-1:0]   target_cell
);
   import pfc_pkg::*;

   logic [SIDE_W-1:0] own_row;
   logic [SIDE_W-1:0] own_col;
   logic [SIDE_W-1:0] other_row;
   logic [SIDE_W-1:0] other_col;

   always_comb begin
      own_row   = pos_row(cell_req.own_pos);
      own_col   = pos_col(cell_req.own_pos);
      other_row = pos_row(cell_req.other_pos);
      other_col = pos_col(cell_req.other_pos);
      if (own_row == other_row) begin
         target_cell = cell_of(own_row, side_step(own_col, cell_req.decrypt));
      end else if (own_col == other_col) begin
         target_cell = cell_of(side_step(own_row, cell_req.decrypt), own_col);
      end else begin
         target_cell = cell_of(own_row, other_col);
      end
   end
endmodule

/* hw/rtl/playfair_digraph_cipher_core.sv */
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Builds a 5x5 key square, then enciphers or deciphers letter pairs.
// ----------------------------------------------------------------------------
// Key letters, a text letter that opens a pair and ignored items are each
// taken in IDLE. The finish item starts a walk over all 26 letters that
// fills the free cells. An item that completes a pair (a text letter or end
// of text) steps through RD_A, RD_B, SQ1, EMIT1, SQ2 and EMIT2, and waits on
// the response side in each EMIT state. The two position lookups and the two
// square lookups go one at a time through the single read port of each RAM
// and the one shared cell unit. Results leave through an output register, so
// the response side may stall without losing data. Both RAMs need no clearing.
module playfair_digraph_cipher_core (
   input  logic         clock,
   input  logic         reset,
   pfc_req_if.sink      req_chan,
   pfc_rsp_if.source    rsp_chan,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   import pfc_pkg::*;

   state_type state_ff, state_in;

   logic                    decrypt_ff;
   logic [LETTER_COUNT-1:0] used_ff, used_in;
   logic [CELL_W:0]         fill_count_ff, fill_count_in;
   logic [LETTER_W-1:0]     walk_ff, walk_in;
   logic [LETTER_W-1:0]     pending_letter_ff, pending_letter_in;
   logic                    pending_valid_ff, pending_valid_in;
   logic                    key_ready_ff, key_ready_in;
   logic [LETTER_W-1:0]     a_ff, a_in;
   logic [LETTER_W-1:0]     b_ff, b_in;
   logic [CELL_W-1:0]       pa_ff, pa_in;
   logic [CELL_W-1:0]       pb_ff, pb_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ASCII_W-1:0]      rsp_letter_ff, rsp_letter_in;
   logic                    rsp_end_ff, rsp_end_in;

   logic                accept;
   action_type          action;
   logic                in_ok;
   logic [LETTER_W-1:0] in_idx;
   logic                do_key;
   logic                do_finish;
   logic                do_pair;
   logic                fill_hit;
   logic                rsp_free;

   logic                wr_en;
   logic [LETTER_W-1:0] wr_letter;
   logic                pos_rd_en;
   logic [LETTER_W-1:0] pos_rd_addr;
   logic [CELL_W-1:0]   pos_rd_data;
   logic                sq_rd_en;
   logic [CELL_W-1:0]   sq_rd_data;
   cell_req_type        cell_req;
   logic [CELL_W-1:0]   target_cell;

   // input decode
   always_comb begin
      accept   = req_chan.valid && req_chan.ready;
      action   = action_type'(req_chan.action);
      in_ok    = (req_chan.letter >= ASCII_A) && (req_chan.letter <= ASCII_Z);
      in_idx   = LETTER_W'(req_chan.letter - ASCII_A);
      if (in_idx == IDX_J) begin
         in_idx = IDX_I;
      end
      do_key    = accept && (action == ACT_KEY) && !key_ready_ff && in_ok &&
                  !used_ff[in_idx] && (fill_count_ff < CELLS_FULL);
      do_finish = accept && (action == ACT_FINISH) && !key_ready_ff;
      do_pair   = accept && key_ready_ff && pending_valid_ff &&
                  (((action == ACT_TEXT) && in_ok) || (action == ACT_END));
      fill_hit  = (walk_ff != IDX_J) && !used_ff[walk_ff] &&
                  (fill_count_ff < CELLS_FULL);
      rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_finish) begin
               state_in = ST_FILL;
            end else if (do_pair) begin
               state_in = ST_RD_A;
            end
         end
         ST_FILL: begin
            if (walk_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_SQ1;
         ST_SQ1:  state_in = ST_EMIT1;
         ST_EMIT1: begin
            if (rsp_free) begin
               state_in = ST_SQ2;
            end
         end
         ST_SQ2:  state_in = ST_EMIT2;
         ST_EMIT2: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_chan.ready    = 1'b0;
      used_in           = used_ff;
      fill_count_in     = fill_count_ff;
      walk_in           = walk_ff;
      pending_letter_in = pending_letter_ff;
      pending_valid_in  = pending_valid_ff;
      key_ready_in      = key_ready_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      pa_in             = pa_ff;
      pb_in             = pb_ff;
      rsp_letter_in     = rsp_letter_ff;
      rsp_end_in        = rsp_end_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      wr_en             = 1'b0;
      wr_letter         = in_idx;
      pos_rd_en         = 1'b0;
      pos_rd_addr       = a_ff;
      sq_rd_en          = 1'b0;
      cell_req.own_pos   = pa_ff;
      cell_req.other_pos = pos_rd_data;
      cell_req.decrypt   = decrypt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (do_key) begin
               wr_en = 1'b1;
            end
            if (do_finish) begin
               walk_in = '0;
            end
            if (accept && key_ready_ff && (action == ACT_TEXT) && in_ok) begin
               if (!pending_valid_ff) begin
                  pending_letter_in = in_idx;
                  pending_valid_in  = 1'b1;
               end else if (pending_letter_ff == in_idx) begin
                  a_in = pending_letter_ff;
                  b_in = IDX_X;
               end else begin
                  a_in             = pending_letter_ff;
                  b_in             = in_idx;
                  pending_valid_in = 1'b0;
               end
            end
            if (do_pair && (action == ACT_END)) begin
               a_in             = pending_letter_ff;
               b_in             = IDX_X;
               pending_valid_in = 1'b0;
            end
         end
         ST_FILL: begin
            wr_letter = walk_ff;
            wr_en     = fill_hit;
            walk_in   = walk_ff + LETTER_W'(1);
            if (walk_ff == IDX_LAST) begin
               key_ready_in = 1'b1;
            end
         end
         ST_RD_A: begin
            pos_rd_en   = 1'b1;
            pos_rd_addr = a_ff;
         end
         ST_RD_B: begin
            pos_rd_en   = 1'b1;
            pos_rd_addr = b_ff;
            pa_in       = pos_rd_data;
         end
         ST_SQ1: begin
            pb_in    = pos_rd_data;
            sq_rd_en = 1'b1;
         end
         ST_EMIT1: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = ASCII_A + ASCII_W'(sq_rd_data);
               rsp_end_in    = 1'b0;
            end
         end
         ST_SQ2: begin
            cell_req.own_pos   = pb_ff;
            cell_req.other_pos = pa_ff;
            sq_rd_en           = 1'b1;
         end
         ST_EMIT2: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = ASCII_A + ASCII_W'(sq_rd_data);
               rsp_end_in    = 1'b1;
            end
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
      if (wr_en) begin
         used_in[wr_letter] = 1'b1;
         fill_count_in      = fill_count_ff + (CELL_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         decrypt_ff       <= 1'b0;
         used_ff          <= '0;
         fill_count_ff    <= '0;
         walk_ff          <= '0;
         pending_letter_ff <= '0;
         pending_valid_ff <= 1'b0;
         key_ready_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         used_ff          <= used_in;
         fill_count_ff    <= fill_count_in;
         walk_ff          <= walk_in;
         pending_letter_ff <= pending_letter_in;
         pending_valid_ff <= pending_valid_in;
         key_ready_ff     <= key_ready_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_wr_en) begin
            decrypt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_letter = rsp_letter_ff;
   assign rsp_chan.pair_end   = rsp_end_ff;

   pfc_cell_unit u_cell_unit (
      .cell_req    (cell_req),
      .target_cell (target_cell)
   );

   // letter -> cell of the square
   pfc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (LETTER_COUNT)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_letter),
      .wr_data (fill_count_ff[CELL_W-1:0]),
      .rd_en   (pos_rd_en),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   // cell -> letter
   pfc_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (CELL_COUNT)
   ) u_square_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[CELL_W-1:0]),
      .wr_data (wr_letter),
      .rd_en   (sq_rd_en),
      .rd_addr (target_cell),
      .rd_data (sq_rd_data)
   );

   a_pending_not_j: assert property (@(posedge clock) disable iff (reset)
      pending_valid_ff |-> (pending_letter_ff != IDX_J))
      else $error("pending letter holds J");

   a_square_full: assert property (@(posedge clock) disable iff (reset)
      $rose(key_ready_ff) |-> (fill_count_ff == CELLS_FULL))
      else $error("key square not full when ready");

   a_key_sticks: assert property (@(posedge clock) disable iff (reset)
      key_ready_ff |=> key_ready_ff)
      else $error("key ready dropped");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT2) && rsp_free |=> rsp_valid_ff && rsp_end_ff)
      else $error("second letter of pair not flagged");
endmodule

/* test/pfc_cipher_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playfair cipher checker
// Watches the request, response and CSR ports, rebuilds the key square and
// the pending text letter, and compares every response letter with the
// digraph letters predicted for the accepted requests.
// ----------------------------------------------------------------------------
module pfc_cipher_checker (
   input  logic        clock,
   input  logic        reset,
   pfc_req_if          req_mon,
   pfc_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int unsigned mismatch_count,
   output int unsigned letters_due
);
   import pfc_pkg::*;

   typedef struct packed {
      logic [ASCII_W-1:0] letter;
      logic               pair_end;
   } cipher_letter_type;

   cipher_letter_type       letters_owed[$];
   logic [LETTER_W-1:0]     square[CELL_COUNT];
   logic [CELL_W-1:0]       home_cell[LETTER_COUNT];
   logic [LETTER_COUNT-1:0] placed;
   logic [CELL_W:0]         cells_filled;
   logic [LETTER_W-1:0]     waiting_letter;
   logic                    waiting;
   logic                    square_done;
   logic                    decrypt;

   function automatic logic fold_letter(input logic [ASCII_W-1:0] ch,
                                        output logic [LETTER_W-1:0] idx);
      logic ok;
      ok  = (ch >= ASCII_A) && (ch <= ASCII_Z);
      idx = LETTER_W'(ch - ASCII_A);
      if (idx == IDX_J) begin
         idx = IDX_I;
      end
      return ok;
   endfunction

   function automatic void place_letter(input logic [LETTER_W-1:0] idx);
      if (cells_filled < CELLS_FULL) begin
         square[cells_filled[CELL_W-1:0]] = idx;
         home_cell[idx] = cells_filled[CELL_W-1:0];
         cells_filled = cells_filled + (CELL_W + 1)'(1);
         placed[idx] = 1'b1;
      end
   endfunction

   function automatic logic [ASCII_W-1:0] cell_char(input int row, input int col);
      return ASCII_A + ASCII_W'(square[row * SQUARE_SIDE + col]);
   endfunction

   function automatic void owe_digraph(input logic [LETTER_W-1:0] first,
                                       input logic [LETTER_W-1:0] second);
      int r1, c1, r2, c2, step;
      logic [ASCII_W-1:0] o1, o2;
      r1 = int'(home_cell[first]) / SQUARE_SIDE;
      c1 = int'(home_cell[first]) % SQUARE_SIDE;
      r2 = int'(home_cell[second]) / SQUARE_SIDE;
      c2 = int'(home_cell[second]) % SQUARE_SIDE;
      step = decrypt ? SQUARE_SIDE - 1 : 1;
      if (r1 == r2) begin
         o1 = cell_char(r1, (c1 + step) % SQUARE_SIDE);
         o2 = cell_char(r2, (c2 + step) % SQUARE_SIDE);
      end else if (c1 == c2) begin
         o1 = cell_char((r1 + step) % SQUARE_SIDE, c1);
         o2 = cell_char((r2 + step) % SQUARE_SIDE, c2);
      end else begin
         o1 = cell_char(r1, c2);
         o2 = cell_char(r2, c1);
      end
      letters_owed.push_back('{letter: o1, pair_end: 1'b0});
      letters_owed.push_back('{letter: o2, pair_end: 1'b1});
   endfunction

   function automatic void absorb_item(input action_type act,
                                       input logic [ASCII_W-1:0] ch);
      logic [LETTER_W-1:0] idx;
      logic                is_letter;
      is_letter = fold_letter(ch, idx);
      case (act)
         ACT_KEY: begin
            if (!square_done && is_letter && !placed[idx]) begin
               place_letter(idx);
            end
         end
         ACT_FINISH: begin
            if (!square_done) begin
               for (int i = 0; i < LETTER_COUNT; i++) begin
                  if (LETTER_W'(i) != IDX_J && !placed[i]) begin
                     place_letter(LETTER_W'(i));
                  end
               end
               square_done = 1'b1;
            end
         end
         ACT_TEXT: begin
            if (square_done && is_letter) begin
               if (!waiting) begin
                  waiting_letter = idx;
                  waiting = 1'b1;
               end else if (waiting_letter == idx) begin
                  owe_digraph(idx, IDX_X);
               end else begin
                  waiting = 1'b0;
                  owe_digraph(waiting_letter, idx);
               end
            end
         end
         ACT_END: begin
            if (square_done && waiting) begin
               waiting = 1'b0;
               owe_digraph(waiting_letter, IDX_X);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void take_letter(input logic [ASCII_W-1:0] got_letter,
                                       input logic got_end);
      cipher_letter_type owed;
      if (letters_owed.size() == 0) begin
         $error("unexpected response: out_letter %0d pair_end %0d", got_letter, got_end);
         mismatch_count = mismatch_count + 1;
      end else begin
         owed = letters_owed.pop_front();
         if (got_letter !== owed.letter) begin
            $error("out_letter expected %0d actual %0d", owed.letter, got_letter);
            mismatch_count = mismatch_count + 1;
         end
         if (got_end !== owed.pair_end) begin
            $error("pair_end expected %0d actual %0d", owed.pair_end, got_end);
            mismatch_count = mismatch_count + 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         letters_owed.delete();
         for (int i = 0; i < CELL_COUNT; i++) begin
            square[i] = '0;
         end
         for (int i = 0; i < LETTER_COUNT; i++) begin
            home_cell[i] = '0;
         end
         placed = '0;
         cells_filled = '0;
         waiting_letter = '0;
         waiting = 1'b0;
         square_done = 1'b0;
         decrypt = 1'b0;
         mismatch_count = 0;
         letters_due <= 0;
      end else begin
         if (csr_wr_en) begin
            decrypt = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            take_letter(rsp_mon.out_letter, rsp_mon.pair_end);
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_item(action_type'(req_mon.action), req_mon.letter);
         end
         letters_due <= letters_owed.size();
      end
   end

endmodule

/* test/tb_playfair_digraph_cipher_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher core testbench
// Builds one key square from directed and random key letters, then streams
// directed and random text through phases that alternate between encipher
// and decipher, with random gaps and stalls on both channels and one long
// response hold-off. The checker predicts and compares every letter.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher_core;
   import pfc_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int TEXT_PHASES   = 8;
   localparam int PHASE_ITEMS   = 190;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic        csr_wr_data;
   int unsigned mismatch_count;
   int unsigned letters_due;
   bit          sender_eager;
   logic [ASCII_W-1:0] last_text;

   pfc_req_if req_chan ();
   pfc_rsp_if rsp_chan ();

   always #(HALF_PERIOD) clock = ~clock;

   playfair_digraph_cipher_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pfc_cipher_checker cipher_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .letters_due    (letters_due)
   );

   function automatic logic [ASCII_W-1:0] ascii7(input byte c);
      return c[ASCII_W-1:0];
   endfunction

   task automatic offer(input action_type act, input logic [ASCII_W-1:0] ch);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.letter <= ch;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (letters_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_item(output bit counted);
      int pick;
      logic [ASCII_W-1:0] ch;
      pick = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 82) begin
         if (pick < 12) begin
            ch = last_text;
         end else if (pick < 18) begin
            ch = ascii7("X");
         end else if (pick < 22) begin
            ch = pick[0] ? ascii7("J") : ascii7("I");
         end else begin
            ch = ASCII_A + ASCII_W'($urandom_range(0, 25));
         end
         last_text = ch;
         offer(ACT_TEXT, ch);
      end else if (pick < 89) begin
         offer(ACT_END, ASCII_W'($urandom()));
      end else begin
         counted = 1'b0;
         if (pick < 94) begin
            offer(ACT_TEXT, ASCII_W'($urandom()));
         end else if (pick < 97) begin
            offer(ACT_KEY, ASCII_W'($urandom()));
         end else begin
            offer(ACT_FINISH, ASCII_W'($urandom()));
         end
      end
   endtask

   // request side and verdict
   initial begin
      int key_len;
      int taken;
      bit counted;
      req_chan.valid  <= 1'b0;
      req_chan.action <= ACT_KEY;
      req_chan.letter <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 1'b0;
      sender_eager    = 1'b0;
      last_text       = ascii7("A");
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // key square, with text before the square is ready
      offer(ACT_KEY, ascii7("J"));
      offer(ACT_KEY, ascii7("P"));
      offer(ACT_KEY, ascii7("A"));
      offer(ACT_KEY, ascii7("P"));
      offer(ACT_KEY, 7'd0);
      offer(ACT_KEY, 7'd127);
      offer(ACT_TEXT, ascii7("A"));
      offer(ACT_END, ascii7("A"));
      key_len = $urandom_range(3, 10);
      repeat (key_len) offer(ACT_KEY, ASCII_A + ASCII_W'($urandom_range(0, 25)));
      offer(ACT_FINISH, '0);
      offer(ACT_FINISH, 7'd127);
      offer(ACT_KEY, ascii7("Z"));

      // edge cases of the text stream
      offer(ACT_END, '0);
      offer(ACT_TEXT, ascii7("A"));
      offer(ACT_TEXT, ascii7("Z"));
      offer(ACT_TEXT, ascii7("J"));
      offer(ACT_TEXT, ascii7("I"));
      offer(ACT_TEXT, 7'd91);
      offer(ACT_END, '0);
      offer(ACT_TEXT, ascii7("X"));
      offer(ACT_TEXT, ascii7("X"));
      offer(ACT_END, 7'd127);
      offer(ACT_TEXT, 7'd64);
      drain();

      for (int phase_idx = 0; phase_idx < TEXT_PHASES; phase_idx++) begin
         write_mode(phase_idx % 2 == 0);
         sender_eager = (phase_idx % 3 == 2);
         taken = 0;
         while (taken < PHASE_ITEMS) begin
            random_item(counted);
            if (counted) begin
               taken++;
            end
         end
         offer(ACT_END, '0);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("tb_playfair_digraph_cipher_core OK");
      end else begin
         $display("tb_playfair_digraph_cipher_core NOT OK");
      end
      $finish;
   end

   // response side
   initial begin
      int stall;
      int letters_taken;
      bit long_hold_done;
      letters_taken  = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!long_hold_done && letters_taken >= HOLD_AFTER) begin
            stall = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (letters_taken % 160 < 40) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         letters_taken++;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_playfair_digraph_cipher_core NOT OK");
      $finish;
   end

endmodule
